// ===== rtl/core/signed_int_to_decimal_ascii_macros.svh =====
// assertion macros used by the datapath rtl file
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SITDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication: when cond holds, result must hold in the next cycle
`define SITDA_ASSERT_NEXT(label, cond, result, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) \
    else $error(msg);

`endif

// ===== rtl/core/sitda_pkg.sv =====
package sitda_pkg;

  // text format constants
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned IDX_W = $clog2(MAX_DIGITS + 1);
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // ceil(2^35 / 10): exact divide by ten for any 32-bit unsigned value
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic divide;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic last_loaded;
  } status_t;

endpackage

// ===== rtl/core/sitda_ctrl.sv =====
module sitda_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output sitda_pkg::cmd_t    cmd,
  input  sitda_pkg::status_t status
);
  import sitda_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIVIDE = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.divide = 1'b1;
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.last_loaded) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/sitda_datapath.sv =====
`include "signed_int_to_decimal_ascii_macros.svh"

module sitda_datapath (
  input  logic               clk,
  input  logic               rst,
  input  sitda_pkg::cmd_t    cmd,
  output sitda_pkg::status_t status,
  input  logic signed [31:0] value,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [7:0]         char_code,
  output logic               last
);
  import sitda_pkg::*;

  logic [31:0]      mag;
  logic             sign_pending;
  logic [3:0]       digits [MAX_DIGITS];
  logic [IDX_W-1:0] ndig;
  logic [IDX_W-1:0] ptr;

  logic [31:0] raw;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] quot_x10;
  logic [3:0]  digit;
  logic        load_out;

  assign raw = value;

  // one decimal digit per cycle by reciprocal multiply
  assign prod = {32'd0, mag} * {32'd0, RECIP_TEN};
  assign quot = {3'd0, prod[63:RECIP_SHIFT]};
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign digit = mag[3:0] - quot_x10[3:0];

  // output register takes a new char when empty or being taken
  assign load_out = cmd.emit && (!out_valid || !out_stall);

  assign status.div_done = (quot == 32'd0);
  assign status.last_loaded = load_out && !sign_pending && (ptr == '0);

  // magnitude, digit store and emit pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ndig <= '0;
      ptr <= '0;
      sign_pending <= 1'b0;
    end else begin
      if (cmd.load) begin
        mag <= raw[31] ? (32'd0 - raw) : raw;
        sign_pending <= raw[31];
        ndig <= '0;
      end
      if (cmd.divide) begin
        digits[ndig] <= digit;
        ndig <= ndig + IDX_W'(1);
        mag <= quot;
        if (quot == 32'd0) begin
          ptr <= ndig;
        end
      end
      if (load_out) begin
        if (sign_pending) begin
          sign_pending <= 1'b0;
        end else if (ptr != '0) begin
          ptr <= ptr - IDX_W'(1);
        end
      end
    end
  end

  // output item payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (sign_pending) begin
        char_code <= CHAR_MINUS;
        last <= 1'b0;
      end else begin
        char_code <= CHAR_ZERO + {4'd0, digits[ptr]};
        last <= (ptr == '0);
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `SITDA_ASSERT(a_char_range, !out_valid || char_code == CHAR_MINUS || (char_code >= CHAR_ZERO && char_code <= CHAR_NINE), "char out of range")
  `SITDA_ASSERT(a_minus_not_last, !(out_valid && char_code == CHAR_MINUS && last), "minus flagged last")
  `SITDA_ASSERT(a_ptr_bound, ptr < IDX_W'(MAX_DIGITS) && ndig <= IDX_W'(MAX_DIGITS), "digit index out of range")
  `SITDA_ASSERT_NEXT(a_digit_follows_minus, load_out && sign_pending, !sign_pending && !last, "minus without digits")

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// steps: the input is loaded, then the divide-by-ten loop stores d digits (1..10),
// one digit per cycle, then the emit pass sends n chars (1..11), n = d plus the minus
// sign if any, one char per cycle while out_stall is low; a new input is taken only once
// the last char is loaded, and the output register lets it start while that char waits
// reset (rst, synchronous): controller idle, output empty, digit counters cleared
module signed_int_to_decimal_ascii (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         char_code,
  output logic               last
);
  import sitda_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // digit extraction and char output
  sitda_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .char_code (char_code),
    .last      (last)
  );

endmodule
